### design/xtes_pkg.sv
package xtes_pkg;

    localparam int XTES_QUEUE_DEPTH = 2;
    localparam int CP_W = 21;
    localparam int RUN_W = 3;

    localparam logic [6:0] CH_AMP  = 7'h26;
    localparam logic [6:0] CH_HASH = 7'h23;
    localparam logic [6:0] CH_SEMI = 7'h3B;
    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_A    = 7'h61;
    localparam logic [6:0] CH_G    = 7'h67;
    localparam logic [6:0] CH_L    = 7'h6C;
    localparam logic [6:0] CH_M    = 7'h6D;
    localparam logic [6:0] CH_O    = 7'h6F;
    localparam logic [6:0] CH_P    = 7'h70;
    localparam logic [6:0] CH_Q    = 7'h71;
    localparam logic [6:0] CH_T    = 7'h74;
    localparam logic [6:0] CH_U    = 7'h75;

    typedef enum logic [2:0] {
        K_PASS = 3'd0,
        K_LT   = 3'd1,
        K_GT   = 3'd2,
        K_AMP  = 3'd3,
        K_QUOT = 3'd4,
        K_NUM  = 3'd5
    } kind_t;

    // one classified character waiting to be expanded
    typedef struct packed {
        kind_t            kind;
        logic [CP_W-1:0]  ch;
        logic [2:0][3:0]  dig;   // decimal digits, most significant in dig[0]
        logic [RUN_W-1:0] len;   // run length in words
        logic             last;  // string end
    } job_t;

endpackage

### design/xtes_classify.sv
module xtes_classify
    import xtes_pkg::*;
(
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [CP_W-1:0] code_point,
    input  logic            s_tlast,
    input  logic            escape_quote,
    input  logic            escape_apostrophe,
    input  logic            queue_full,
    output logic            push,
    output job_t            job
);

    function automatic logic [2:0][3:0] to_dec(input logic [7:0] v);
        logic [2:0][3:0] d;
        logic [6:0]      r;
        logic [3:0]      t;
        d = '0;
        t = '0;
        r = (v >= 8'd100) ? 7'(v - 8'd100) : v[6:0];
        for (int k = 1; k < 10; k++)
        begin
            if (r >= 7'(10 * k))
            begin
                t = 4'(k);
            end
        end
        d[0] = (v >= 8'd100) ? 4'd1 : 4'd0;
        d[1] = t;
        d[2] = 4'(r - 7'(t) * 7'd10);
        return d;
    endfunction

    logic            ctl;
    logic [2:0][3:0] dec;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    assign ctl = (code_point <= CP_W'(8))
              || (code_point >= CP_W'(11) && code_point <= CP_W'(31)
                  && code_point != CP_W'(13))
              || (code_point >= CP_W'(127) && code_point <= CP_W'(159)
                  && code_point != CP_W'(133));

    assign dec = to_dec(code_point[7:0]);

    always_comb
    begin
        job.ch   = code_point;
        job.last = s_tlast;
        job.dig  = '0;
        job.kind = K_PASS;
        job.len  = RUN_W'(1);
        if (code_point == CP_W'(8'h3C))
        begin
            job.kind = K_LT;
            job.len  = RUN_W'(4);
        end
        else if (code_point == CP_W'(8'h3E))
        begin
            job.kind = K_GT;
            job.len  = RUN_W'(4);
        end
        else if (code_point == CP_W'(8'h26))
        begin
            job.kind = K_AMP;
            job.len  = RUN_W'(5);
        end
        else if (code_point == CP_W'(8'h22) && escape_quote)
        begin
            job.kind = K_QUOT;
            job.len  = RUN_W'(6);
        end
        else if (code_point == CP_W'(8'h27) && escape_apostrophe)
        begin
            job.kind   = K_NUM;
            job.dig[0] = 4'd3;
            job.dig[1] = 4'd9;
            job.len    = RUN_W'(5);
        end
        else if (ctl)
        begin
            job.kind = K_NUM;
            if (code_point <= CP_W'(8))
            begin
                job.dig[0] = dec[2];
                job.len    = RUN_W'(4);
            end
            else if (code_point <= CP_W'(31))
            begin
                job.dig[0] = dec[1];
                job.dig[1] = dec[2];
                job.len    = RUN_W'(5);
            end
            else
            begin
                job.dig = dec;
                job.len = RUN_W'(6);
            end
        end
    end

endmodule

### design/xtes_queue.sv
module xtes_queue
    import xtes_pkg::*;
#(
    parameter int DEPTH = XTES_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### design/xtes_expand.sv
module xtes_expand
    import xtes_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  job_t            job,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [CP_W-1:0] out_char,
    output logic            m_tlast,
    output logic            m_tuser
);

    function automatic logic [6:0] named_char(input kind_t k, input logic [RUN_W-1:0] i);
        logic [6:0] c;
        c = CH_SEMI;
        if (i == RUN_W'(0))
        begin
            c = CH_AMP;
        end
        else
        begin
            case (k)
                K_LT:
                begin
                    c = (i == RUN_W'(1)) ? CH_L : (i == RUN_W'(2)) ? CH_T : CH_SEMI;
                end
                K_GT:
                begin
                    c = (i == RUN_W'(1)) ? CH_G : (i == RUN_W'(2)) ? CH_T : CH_SEMI;
                end
                K_AMP:
                begin
                    c = (i == RUN_W'(1)) ? CH_A : (i == RUN_W'(2)) ? CH_M
                      : (i == RUN_W'(3)) ? CH_P : CH_SEMI;
                end
                K_QUOT:
                begin
                    c = (i == RUN_W'(1)) ? CH_Q : (i == RUN_W'(2)) ? CH_U
                      : (i == RUN_W'(3)) ? CH_O : (i == RUN_W'(4)) ? CH_T : CH_SEMI;
                end
                default:
                begin
                    c = CH_SEMI;
                end
            endcase
        end
        return c;
    endfunction

    logic [RUN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [CP_W-1:0]  char_reg, char_next;
    logic             last_reg, last_next;
    logic             end_reg, end_next;
    logic             advance;
    logic             fire;
    logic             run_done;
    logic [RUN_W-1:0] dpos;

    assign advance  = !valid_reg || m_tready;
    assign fire     = advance && job_valid;
    assign run_done = (idx_reg == job.len - 1'b1);
    assign pop      = fire && run_done;
    assign dpos     = idx_reg - RUN_W'(2);

    always_comb
    begin
        case (job.kind)
            K_PASS:
            begin
                char_next = job.ch;
            end
            K_NUM:
            begin
                if (idx_reg == RUN_W'(0))
                begin
                    char_next = CP_W'(CH_AMP);
                end
                else if (idx_reg == RUN_W'(1))
                begin
                    char_next = CP_W'(CH_HASH);
                end
                else if (run_done)
                begin
                    char_next = CP_W'(CH_SEMI);
                end
                else
                begin
                    char_next = CP_W'(CH_ZERO + 7'(job.dig[dpos[1:0]]));
                end
            end
            default:
            begin
                char_next = CP_W'(named_char(job.kind, idx_reg));
            end
        endcase
        last_next  = run_done;
        end_next   = run_done && job.last;
        valid_next = advance ? job_valid : valid_reg;
        idx_next   = idx_reg;
        if (fire)
        begin
            idx_next = run_done ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
            end_reg  <= end_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign out_char = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = end_reg;

endmodule

### design/xml_text_escape_stream.sv
// XML text escaper, one Unicode code point in, its escaped text out.
// Input stream s_*: one word per source character, code point in tdata,
// tlast marks the final character of a string.
// Output stream m_*: one word per output character; tlast marks the last
// character of each input's run, tuser marks that word when it also ends
// the string. Runs are 1 word (pass-through), 4 to 6 words (&lt; &gt; &amp;
// &quot; &#39; and &#N; for control characters).
// The first output word passes through the queue and then the output register.
// Throughput: one output word per cycle while m_tready is high, set by the
// expander; an input of run length L holds the expander for L words, so
// pass-through text moves at one character per cycle. A two-entry queue
// sits between classifier and expander; s_tready drops only when it is full.
// m_tvalid/m_tdata are registered and hold while m_tready is low.
// APB registers: 0x0 escape_quote (reset 1), 0x4 escape_apostrophe (reset 0);
// write only while the stream is idle.
// Reset clears the queue and the output valid flag; no words are lost after.
module xml_text_escape_stream
    import xtes_pkg::*;
#(
    parameter int QUEUE_DEPTH = XTES_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] out_char
    output logic        m_tlast,
    output logic        m_tuser,   // [0] string_end_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            escape_quote_reg;
    logic            escape_apostrophe_reg;
    logic            cfg_wr;
    logic            push;
    logic            full;
    logic            pop;
    logic            head_valid;
    job_t            push_job;
    job_t            head_job;
    logic [CP_W-1:0] out_char;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {31'b0, paddr[2] ? escape_apostrophe_reg : escape_quote_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_quote_reg      <= 1'b1;
            escape_apostrophe_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                escape_apostrophe_reg <= pwdata[0];
            end
            else
            begin
                escape_quote_reg <= pwdata[0];
            end
        end
    end

    xtes_classify u_classify (
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .code_point        (s_tdata[CP_W-1:0]),
        .s_tlast           (s_tlast),
        .escape_quote      (escape_quote_reg),
        .escape_apostrophe (escape_apostrophe_reg),
        .queue_full        (full),
        .push              (push),
        .job               (push_job)
    );

    xtes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    xtes_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_char  (out_char),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    assign m_tdata = {3'b0, out_char};

endmodule

### design/xtes_check.sv
module xtes_check
    import xtes_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // string end only on the last word of a run
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("string end outside run end");

    // angle brackets never leave unescaped
    a_no_brackets: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[20:0] != 21'h3C && m_tdata[20:0] != 21'h3E)
        else $error("raw angle bracket in output");

    // an ampersand always opens a reference, never ends a run
    a_amp_opens: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20:0] == 21'h26 |-> !m_tlast)
        else $error("ampersand at run end");

endmodule

bind xml_text_escape_stream xtes_check u_check (.*);
